>>> hw/rtl/level_set_curvature_flux_defines.svh
// ----------------------------------------------------------------------------
// level_set_curvature_flux assertion macros
// shared property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef LEVEL_SET_CURVATURE_FLUX_DEFINES_SVH
`define LEVEL_SET_CURVATURE_FLUX_DEFINES_SVH

// same-cycle implication
`define LSCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("level_set_curvature_flux check failed");

// next-cycle implication
`define LSCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("level_set_curvature_flux check failed");

`endif

>>> hw/rtl/lscf_pkg.sv
// ----------------------------------------------------------------------------
// lscf_pkg
// types shared by the curvature flux pipeline and its divider steps
// ----------------------------------------------------------------------------
package lscf_pkg;

	localparam int QBITS = 33;   // quotient bits resolved by the divider
	localparam int DEN_W = 34;   // squared gradient width

	typedef enum logic [1:0] {
		CASE_DIV  = 2'd0,
		CASE_ZERO = 2'd1,
		CASE_MEAN = 2'd2
	} flux_case_t;

	typedef struct packed {
		logic              in_band;
		flux_case_t        fcase;
		logic              neg;
		logic              ovf;
		logic signed [19:0] mean_sum;
		logic [19:0]       idx;
	} side_t;

	typedef struct packed {
		logic             valid;
		side_t            side;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [QBITS-1:0] low;
		logic [QBITS-1:0] quo;
	} div_t;

endpackage

>>> hw/rtl/lscf_div_step.sv
// ----------------------------------------------------------------------------
// lscf_div_step
// one restoring division step: resolves one quotient bit per stage
// ----------------------------------------------------------------------------
module lscf_div_step
	import lscf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;
	div_t             nxt;

	always_comb begin
		trial = {d_in.rem, d_in.low[QBITS-1]};
		ge    = trial >= {1'b0, d_in.den};
		diff  = trial - {1'b0, d_in.den};
		nxt       = d_in;
		nxt.rem   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		nxt.low   = {d_in.low[QBITS-2:0], 1'b0};
		nxt.quo   = {d_in.quo[QBITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out <= nxt;
		end
	end

endmodule

>>> hw/rtl/level_set_curvature_flux.sv
// ----------------------------------------------------------------------------
// level_set_curvature_flux
// mean-curvature diffusion flux of a 3x3 level-set window
// ----------------------------------------------------------------------------
// usage:
//   input channel: nine Q8.8 samples plus pixel_index, in_valid / in_ready
//   output channel: out_index, in_band, flux_value, flux_case, saturated,
//   out_valid / out_ready
//   config: APB-style port, registers at byte addresses 0, 8, 16, 64-bit data
// depth: 5 arithmetic stages, 33 one-bit divider stages, one output register
// throughput: one window per cycle while the output is not held; the 33-stage
//   restoring divider for the numerator over the squared gradient sets the depth
// stall: a held output freezes the whole pipeline and drops in_ready; nothing
//   is lost or repeated, and the pipeline resumes as soon as out_ready returns
// reset: all valid bits clear; band_limit 768, gradient_floor 1,
//   curvature_floor 67109
// ----------------------------------------------------------------------------
module level_set_curvature_flux
	import lscf_pkg::*;
#(
	parameter int INDEX_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] up_left,
	input  logic signed [15:0] up_mid,
	input  logic signed [15:0] up_right,
	input  logic signed [15:0] mid_left,
	input  logic signed [15:0] center_value,
	input  logic signed [15:0] mid_right,
	input  logic signed [15:0] down_left,
	input  logic signed [15:0] down_mid,
	input  logic signed [15:0] down_right,
	input  logic [19:0]        pixel_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [19:0]        out_index,
	output logic               in_band,
	output logic signed [31:0] flux_value,
	output logic [1:0]         flux_case,
	output logic               saturated
);

	localparam int KEEP_BITS = (INDEX_BITS < 20) ? INDEX_BITS : 20;
	localparam logic [19:0] IDX_MASK = 20'((64'd1 << KEEP_BITS) - 64'd1);

	localparam logic [1:0] REG_BAND   = 2'd0;
	localparam logic [1:0] REG_GFLOOR = 2'd1;
	localparam logic [1:0] REG_CFLOOR = 2'd2;

	// configuration
	logic [14:0]        band_limit_q;
	logic [31:0]        gradient_floor_q;
	logic signed [47:0] curvature_floor_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_limit_q      <= 15'd768;
			gradient_floor_q  <= 32'd1;
			curvature_floor_q <= 48'sd67109;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_BAND:   band_limit_q      <= pwdata[14:0];
				REG_GFLOOR: gradient_floor_q  <= pwdata[31:0];
				REG_CFLOOR: curvature_floor_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_BAND:   prdata = {49'd0, band_limit_q};
			REG_GFLOOR: prdata = {32'd0, gradient_floor_q};
			REG_CFLOOR: prdata = {{16{curvature_floor_q[47]}}, curvature_floor_q};
			default:    prdata = 64'd0;
		endcase
	end

	// pipeline enable: everything moves unless the output is held
	logic en;
	logic out_v_q;

	assign en       = !(out_v_q && !out_ready);
	assign in_ready = en;

	// stage 1: differences and band test
	logic               v_s1, inb_s1;
	logic signed [16:0] ax_s1, ay_s1;
	logic signed [18:0] bxx_s1, byy_s1, cxy_s1;
	logic [19:0]        idx_s1;
	logic [16:0]        mag;

	assign mag = center_value[15] ? 17'(-$signed({center_value[15], center_value}))
	                              : {1'b0, center_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inb_s1 <= mag < {2'b0, band_limit_q};
			ax_s1  <= 17'(mid_right) - 17'(mid_left);
			ay_s1  <= 17'(down_mid) - 17'(up_mid);
			bxx_s1 <= 19'(mid_right) + 19'(mid_left) - (19'(center_value) <<< 1);
			byy_s1 <= 19'(down_mid) + 19'(up_mid) - (19'(center_value) <<< 1);
			cxy_s1 <= 19'(down_right) + 19'(up_left) - 19'(up_right) - 19'(down_left);
			idx_s1 <= pixel_index & IDX_MASK;
		end
	end

	// stage 2: gradient products
	logic               v_s2, inb_s2;
	logic signed [33:0] ax2_s2, ay2_s2, axay_s2;
	logic signed [18:0] bxx_s2, byy_s2, cxy_s2;
	logic signed [19:0] sum_s2;
	logic [19:0]        idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inb_s2  <= inb_s1;
			ax2_s2  <= ax_s1 * ax_s1;
			ay2_s2  <= ay_s1 * ay_s1;
			axay_s2 <= ax_s1 * ay_s1;
			bxx_s2  <= bxx_s1;
			byy_s2  <= byy_s1;
			cxy_s2  <= cxy_s1;
			sum_s2  <= 20'(bxx_s1) + 20'(byy_s1);
			idx_s2  <= idx_s1;
		end
	end

	// stage 3: curvature terms and squared gradient
	logic               v_s3, inb_s3;
	logic [33:0]        g2_s3;
	logic signed [52:0] t1_s3, t2_s3, t3_s3;
	logic signed [19:0] sum_s3;
	logic [19:0]        idx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inb_s3 <= inb_s2;
			g2_s3  <= 34'(ax2_s2) + 34'(ay2_s2);
			t1_s3  <= byy_s2 * ax2_s2;
			t2_s3  <= axay_s2 * cxy_s2;
			t3_s3  <= bxx_s2 * ay2_s2;
			sum_s3 <= sum_s2;
			idx_s3 <= idx_s2;
		end
	end

	// stage 4: numerator
	logic               v_s4, inb_s4;
	logic [33:0]        g2_s4;
	logic signed [55:0] num_s4;
	logic signed [19:0] sum_s4;
	logic [19:0]        idx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inb_s4 <= inb_s3;
			g2_s4  <= g2_s3;
			num_s4 <= (56'(t1_s3) <<< 1) - 56'(t2_s3) + (56'(t3_s3) <<< 1);
			sum_s4 <= sum_s3;
			idx_s4 <= idx_s3;
		end
	end

	// stage 5: case selection and divider setup
	div_t               div_s5;
	div_t               div_nxt;
	logic [54:0]        num_mag;
	logic [61:0]        dvd;
	logic signed [56:0] cf2;
	logic               g_above, g_below;

	always_comb begin
		num_mag = num_s4[55] ? 55'(-num_s4) : num_s4[54:0];
		dvd     = {num_mag, 7'd0};
		cf2     = 57'(curvature_floor_q) <<< 1;
		g_above = g2_s4 > {2'b0, gradient_floor_q};
		g_below = g2_s4 < {2'b0, gradient_floor_q};

		div_nxt                = '0;
		div_nxt.valid          = v_s4;
		div_nxt.side.in_band   = inb_s4;
		div_nxt.side.mean_sum  = sum_s4;
		div_nxt.side.idx       = idx_s4;
		div_nxt.side.neg       = num_s4[55];
		div_nxt.side.ovf       = {5'd0, dvd[61:QBITS]} >= g2_s4;
		div_nxt.den            = g2_s4;
		div_nxt.rem            = {5'd0, dvd[61:QBITS]};
		div_nxt.low            = dvd[QBITS-1:0];
		div_nxt.quo            = '0;
		if (g_above) begin
			div_nxt.side.fcase = CASE_DIV;
		end else if (g_below && (57'(num_s4) < cf2)) begin
			div_nxt.side.fcase = CASE_ZERO;
		end else begin
			div_nxt.side.fcase = CASE_MEAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s5 <= '0;
		end else if (en) begin
			div_s5 <= div_nxt;
		end
	end

	// divider: one quotient bit per stage
	div_t st [0:QBITS];

	assign st[0] = div_s5;

	for (genvar i = 0; i < QBITS; i++) begin : g_div
		lscf_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (st[i]),
			.d_out  (st[i+1])
		);
	end

	// output formatting and register
	div_t               fin;
	logic               sat_d;
	logic signed [31:0] flux_d;
	logic [QBITS-1:0]   q;

	assign fin = st[QBITS];
	assign q   = fin.quo;

	always_comb begin
		sat_d  = 1'b0;
		flux_d = '0;
		if (fin.side.in_band) begin
			case (fin.side.fcase)
				CASE_DIV: begin
					if (fin.side.neg) begin
						// magnitude above 2^31 does not fit the negative rail
						sat_d  = fin.side.ovf || (q > 33'h080000000);
						flux_d = sat_d ? 32'sh80000000 : 32'd0 - q[31:0];
					end else begin
						sat_d  = fin.side.ovf || q[32] || q[31];
						flux_d = sat_d ? 32'sh7fffffff : q[31:0];
					end
				end
				CASE_MEAN: flux_d = 32'(fin.side.mean_sum) <<< 7;
				default:   flux_d = '0;
			endcase
		end
	end

	logic [19:0]        idx_q;
	logic               inb_q, sat_q;
	logic signed [31:0] flux_q;
	flux_case_t         case_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q  <= fin.side.idx;
			inb_q  <= fin.side.in_band;
			sat_q  <= sat_d;
			flux_q <= flux_d;
			case_q <= fin.side.in_band ? fin.side.fcase : CASE_DIV;
		end
	end

	assign out_valid  = out_v_q;
	assign out_index  = idx_q;
	assign in_band    = inb_q;
	assign flux_value = flux_q;
	assign flux_case  = case_q;
	assign saturated  = sat_q;

endmodule

>>> hw/rtl/lscf_checker.sv
// ----------------------------------------------------------------------------
// lscf_checker
// port-level checks on the curvature flux block, bound to the top level
// ----------------------------------------------------------------------------
`include "level_set_curvature_flux_defines.svh"

module lscf_checker
	import lscf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               in_band,
	input logic signed [31:0] flux_value,
	input logic [1:0]         flux_case,
	input logic               saturated
);

	// a held result must not move
	`LSCF_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(flux_value))

	// a held result backs up the input side
	`LSCF_ASSERT_NOW(a_backpressure, clk, arst_n, out_valid && !out_ready, !in_ready)

	// out of band results carry nothing
	`LSCF_ASSERT_NOW(a_out_band, clk, arst_n, out_valid && !in_band, flux_value == 32'sd0 && flux_case == CASE_DIV && !saturated)

	// clipping only lands on a rail and only on the divide case
	`LSCF_ASSERT_NOW(a_sat_rail, clk, arst_n, out_valid && saturated, flux_case == CASE_DIV && (flux_value == 32'sh7fffffff || flux_value == 32'sh80000000))

	// forced zero really is zero
	`LSCF_ASSERT_NOW(a_zero_case, clk, arst_n, out_valid && flux_case == CASE_ZERO, flux_value == 32'sd0 && in_band)

endmodule

bind level_set_curvature_flux lscf_checker u_lscf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.in_band    (in_band),
	.flux_value (flux_value),
	.flux_case  (flux_case),
	.saturated  (saturated)
);

>>> verif/tb_level_set_curvature_flux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_level_set_curvature_flux
// randomized and directed check of the curvature flux pipeline against an internal predictor
// ----------------------------------------------------------------------------
module tb_level_set_curvature_flux;
	import lscf_pkg::*;

	localparam int LATENCY = 39;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [4:0] ADDR_BAND = 5'd0;
	localparam logic [4:0] ADDR_GRAD = 5'd8;
	localparam logic [4:0] ADDR_CURV = 5'd16;

	typedef struct {
		logic signed [15:0] s [9];
		logic [19:0] idx;
	} window_t;

	typedef struct {
		logic [19:0] idx;
		logic inb;
		logic signed [31:0] flux;
		flux_case_t fcase;
		logic sat;
	} flux_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] s_ul, s_um, s_ur, s_ml, s_c, s_mr, s_dl, s_dm, s_dr;
	logic [19:0] pixel_index, out_index;
	logic in_band, saturated;
	logic signed [31:0] flux_value;
	logic [1:0] flux_case;

	level_set_curvature_flux u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.up_left(s_ul), .up_mid(s_um), .up_right(s_ur),
		.mid_left(s_ml), .center_value(s_c), .mid_right(s_mr),
		.down_left(s_dl), .down_mid(s_dm), .down_right(s_dr),
		.pixel_index(pixel_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(out_index), .in_band(in_band), .flux_value(flux_value),
		.flux_case(flux_case), .saturated(saturated)
	);

	// predictor copy of the registers
	logic [14:0] band_limit_q;
	logic [31:0] grad_floor_q;
	logic signed [47:0] curv_floor_q;

	window_t window_q[$];
	flux_t flux_expect_q[$];
	int errors, mismatches, idle_cycles;
	bit calm, hold_long;
	int send_gap, recv_gap;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic flux_t predict_flux(window_t w);
		flux_t r;
		longint ul, um, ur, ml, c, mr, dl, dm, dr;
		longint mag, ax, ay, bxx, byy, cxy, g2, num, q;
		ul = w.s[0]; um = w.s[1]; ur = w.s[2];
		ml = w.s[3]; c = w.s[4]; mr = w.s[5];
		dl = w.s[6]; dm = w.s[7]; dr = w.s[8];
		r.idx = w.idx;
		r.inb = 0; r.flux = 0; r.fcase = CASE_DIV; r.sat = 0;
		mag = (c < 0) ? -c : c;
		if (mag < longint'(band_limit_q)) begin
			ax = mr - ml;
			ay = dm - um;
			bxx = mr - 2 * c + ml;
			byy = dm - 2 * c + um;
			cxy = (dr + ul) - (ur + dl);
			g2 = ax * ax + ay * ay;
			num = 2 * byy * ax * ax - ax * ay * cxy + 2 * bxx * ay * ay;
			r.inb = 1;
			if (g2 > longint'(grad_floor_q)) begin
				q = (num * 128) / g2;
				if (q > 64'sd2147483647) begin
					q = 64'sd2147483647; r.sat = 1;
				end else if (q < -64'sd2147483648) begin
					q = -64'sd2147483648; r.sat = 1;
				end
				r.flux = q[31:0];
			end else if (g2 < longint'(grad_floor_q) &&
					num < 2 * longint'(curv_floor_q)) begin
				r.fcase = CASE_ZERO;
			end else begin
				r.fcase = CASE_MEAN;
				q = (bxx + byy) * 128;
				r.flux = q[31:0];
			end
		end
		return r;
	endfunction

	task automatic write_reg(input logic [4:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (addr)
			ADDR_BAND: band_limit_q = data[14:0];
			ADDR_GRAD: grad_floor_q = data[31:0];
			default:   curv_floor_q = data[47:0];
		endcase
	endtask

	task automatic wait_drained();
		while (window_q.size() != 0 || flux_expect_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1536)) - 768);
			default: return 16'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	task automatic push_window(input logic signed [15:0] v [9], input logic [19:0] idx);
		window_t w;
		w.s = v;
		w.idx = idx;
		window_q.push_back(w);
	endtask

	task automatic push_random(int n);
		logic signed [15:0] v [9];
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 2);
			foreach (v[k]) v[k] = rand_sample(mode);
			// sometimes a flat window, to hit the zero and mean cases
			if ($urandom_range(0, 7) == 0) begin
				foreach (v[k]) v[k] = v[4] + 16'($signed($urandom_range(0, 2)) - 1);
			end
			push_window(v, 20'($urandom));
		end
	endtask

	task automatic push_directed();
		logic signed [15:0] v [9];
		foreach (v[k]) v[k] = 0;
		push_window(v, 20'h00000);
		foreach (v[k]) v[k] = 16'sh7fff;
		push_window(v, 20'hfffff);
		foreach (v[k]) v[k] = -16'sd32768;
		push_window(v, 20'h55555);
		foreach (v[k]) v[k] = (k % 2) ? 16'sh7fff : -16'sd32768;
		v[4] = 0;
		push_window(v, 20'haaaaa);
		foreach (v[k]) v[k] = (k % 2) ? -16'sd32768 : 16'sh7fff;
		v[4] = 0;
		push_window(v, 20'h12345);
		// steep gradient, large curvature: saturation both ways
		v = '{-16'sd32768, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sd0, -16'sd32768,
			16'sh7fff, 16'sd0, -16'sd32768};
		push_window(v, 20'h1);
		v = '{16'sh7fff, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sh7fff,
			-16'sd32768, 16'sh7fff, 16'sh7fff};
		push_window(v, 20'h2);
		// centre exactly at band edge and just inside
		foreach (v[k]) v[k] = 16'sd767;
		push_window(v, 20'h3);
		v[4] = 16'sd766;
		push_window(v, 20'h4);
		v[4] = -16'sd767;
		push_window(v, 20'h5);
		// gradient equal to floor (g2 = 1)
		foreach (v[k]) v[k] = 0;
		v[5] = 1;
		push_window(v, 20'h6);
		// gradient zero, curvature below floor
		foreach (v[k]) v[k] = 0;
		v[1] = -5; v[7] = -5;
		push_window(v, 20'h7);
		v[1] = 5; v[7] = 5;
		push_window(v, 20'h8);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			send_gap <= 0;
		end else begin
			if (!in_valid || in_ready) begin
				if (in_valid && in_ready) void'(window_q.pop_front());
				if (send_gap > 0) begin
					in_valid <= 0;
					send_gap <= send_gap - 1;
				end else if (window_q.size() > (in_valid && in_ready ? 0 : 0) &&
						window_q.size() != 0) begin
					in_valid <= 1;
					s_ul <= window_q[0].s[0]; s_um <= window_q[0].s[1];
					s_ur <= window_q[0].s[2]; s_ml <= window_q[0].s[3];
					s_c <= window_q[0].s[4]; s_mr <= window_q[0].s[5];
					s_dl <= window_q[0].s[6]; s_dm <= window_q[0].s[7];
					s_dr <= window_q[0].s[8]; pixel_index <= window_q[0].idx;
					if (!calm && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 5);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// prediction made at acceptance, with the registers in force
	always @(posedge clk) begin
		window_t w;
		if (arst_n && in_valid && in_ready) begin
			w.s = '{s_ul, s_um, s_ur, s_ml, s_c, s_mr, s_dl, s_dm, s_dr};
			w.idx = pixel_index;
			flux_expect_q.push_back(predict_flux(w));
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			recv_gap <= 0;
		end else if (hold_long) begin
			out_ready <= 0;
		end else if (recv_gap > 0) begin
			out_ready <= 0;
			recv_gap <= recv_gap - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_ready <= 0;
			recv_gap <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		flux_t e;
		if (arst_n && out_valid && out_ready) begin
			if (flux_expect_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result idx=%h", out_index);
			end else begin
				e = flux_expect_q.pop_front();
				if (out_index !== e.idx || in_band !== e.inb || flux_value !== e.flux ||
						flux_case !== e.fcase || saturated !== e.sat) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch exp idx=%h inb=%b flux=%h case=%0d sat=%b got idx=%h inb=%b flux=%h case=%0d sat=%b",
							e.idx, e.inb, e.flux, e.fcase, e.sat,
							out_index, in_band, flux_value, flux_case, saturated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || hold_long)
			idle_cycles <= 0;
		else if (window_q.size() != 0 || flux_expect_q.size() != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		errors = 0; mismatches = 0; idle_cycles = 0;
		calm = 0; hold_long = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_ul = 0; s_um = 0; s_ur = 0; s_ml = 0; s_c = 0; s_mr = 0;
		s_dl = 0; s_dm = 0; s_dr = 0; pixel_index = 0;
		band_limit_q = 15'd768; grad_floor_q = 32'd1; curv_floor_q = 48'sd67109;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		push_directed();
		wait_drained();

		write_reg(ADDR_BAND, 64'd32767);
		write_reg(ADDR_GRAD, 64'd0);
		write_reg(ADDR_CURV, 64'h0000_7fff_ffff_ffff);
		push_directed();
		push_random(200);
		// long receiver hold so the pipeline backs up into in_ready
		hold_long = 1;
		repeat (150) @(posedge clk);
		hold_long = 0;
		wait_drained();

		write_reg(ADDR_BAND, 64'd0);
		write_reg(ADDR_GRAD, 64'hffff_ffff);
		write_reg(ADDR_CURV, 64'h0000_8000_0000_0000);
		push_random(60);
		wait_drained();

		write_reg(ADDR_BAND, 64'd20000);
		write_reg(ADDR_GRAD, 64'd4000);
		write_reg(ADDR_CURV, 64'd0);
		push_random(300);
		wait_drained();

		write_reg(ADDR_BAND, {49'd0, 15'($urandom)});
		write_reg(ADDR_GRAD, 64'($urandom_range(0, 2000)));
		write_reg(ADDR_CURV, {$urandom, $urandom});
		push_random(300);
		wait_drained();

		write_reg(ADDR_BAND, 64'd768);
		write_reg(ADDR_GRAD, 64'd1);
		write_reg(ADDR_CURV, 64'd67109);
		calm = 1;
		push_random(200);
		wait_drained();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
